// ----- design/mfrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfrd_pkg
// Types, constants and lookup functions shared by the meter frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfrd_pkg;

  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned IDENT_W = 32;
  localparam int unsigned VALUE_W = 28;
  localparam int unsigned QTY_W   = 5;
  localparam int unsigned DEC_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [7:0]       START_BYTE  = 8'h68;
  localparam logic [7:0]       DATA_BIAS   = 8'h33;
  localparam logic [7:0]       ADDR_BYTES  = 8'd6;
  localparam logic [QTY_W-1:0] Q_UNKNOWN   = 5'd20;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_ADDR,
    PH_START2,
    PH_CTRL,
    PH_LEN,
    PH_DATA,
    PH_CSUM
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_CSUM_ERR,
    ST_BAD_START
  } status_t;

  typedef enum logic [1:0] {
    VF_FOUR,
    VF_THREE,
    VF_TWO,
    VF_NONE
  } form_t;

  // Identifier to quantity code; anything not listed is unknown.
  function automatic logic [QTY_W-1:0] qty_lookup(input logic [IDENT_W-1:0] ident);
    case (ident)
      32'h00010000: return 5'd0;
      32'h00020000: return 5'd1;
      32'h00030000: return 5'd2;
      32'h00040000: return 5'd3;
      32'h02060000: return 5'd4;
      32'h02030000: return 5'd5;
      32'h02040000: return 5'd6;
      32'h02050000: return 5'd7;
      32'h02010100: return 5'd8;
      32'h02010200: return 5'd9;
      32'h02010300: return 5'd10;
      32'h02020100: return 5'd11;
      32'h02020200: return 5'd12;
      32'h02020300: return 5'd13;
      32'h02060100: return 5'd14;
      32'h02060200: return 5'd15;
      32'h02060300: return 5'd16;
      32'h02070100: return 5'd17;
      32'h02070200: return 5'd18;
      32'h02070300: return 5'd19;
      default:      return Q_UNKNOWN;
    endcase
  endfunction

  // Number of value bytes used for each quantity
  function automatic form_t qty_form(input logic [QTY_W-1:0] q);
    case (q)
      5'd0, 5'd1, 5'd2, 5'd3:                             return VF_FOUR;
      5'd5, 5'd6, 5'd7, 5'd11, 5'd12, 5'd13:              return VF_THREE;
      5'd4, 5'd8, 5'd9, 5'd10, 5'd14, 5'd15, 5'd16,
      5'd17, 5'd18, 5'd19:                                return VF_TWO;
      default:                                            return VF_NONE;
    endcase
  endfunction

  function automatic logic [DEC_W-1:0] qty_decimals(input logic [QTY_W-1:0] q);
    case (q)
      5'd0, 5'd1, 5'd2, 5'd3:                             return 3'd2;
      5'd4, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16:     return 3'd3;
      5'd5, 5'd6, 5'd7:                                   return 3'd4;
      5'd8, 5'd9, 5'd10, 5'd17, 5'd18, 5'd19:             return 3'd1;
      default:                                            return 3'd0;
    endcase
  endfunction

  // Two BCD digits to binary; digits above nine are taken at face value
  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'b0, b[7:4]};
    return {4'b0, b[3:0]} + (hi << 3) + (hi << 1);
  endfunction

endpackage

`default_nettype wire

// ----- design/mfrd_if.sv -----
// ----------------------------------------------------------------------------
// mfrd_in_if / mfrd_out_if
// Valid/ready channels for received bytes and decoded frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mfrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  frame_status;
  logic [47:0] meter_address;
  logic [7:0]  control_code;
  logic [7:0]  data_length;
  logic [31:0] data_identifier;
  logic [4:0]  quantity_code;
  logic [27:0] measured_value;
  logic [2:0]  decimal_places;

  modport source (
    output valid, output frame_status, output meter_address, output control_code,
    output data_length, output data_identifier, output quantity_code,
    output measured_value, output decimal_places, input ready
  );
  modport sink (
    input valid, input frame_status, input meter_address, input control_code,
    input data_length, input data_identifier, input quantity_code,
    input measured_value, input decimal_places, output ready
  );
endinterface

`default_nettype wire

// ----- design/meter_frame_receiver_decoder.sv -----
// ----------------------------------------------------------------------------
// meter_frame_receiver_decoder
// Deframes meter-link bytes, checks the byte sum and decodes the reading.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | role
//  rx      | in  | rx_byte                                      | received bytes
//  res     | out | frame_status, meter_address, control_code,   | one per frame
//          |     | data_length, data_identifier, quantity_code, |
//          |     | measured_value, decimal_places               |
//
//  One byte is taken every cycle while rx.ready is high; the frame state updates in the same cycle.
//  The result appears in the cycle after its closing byte, held in the output register.
//  A waiting result blocks rx only while res.ready is low; it drains and refills in
//  the same cycle. Reset returns the receiver to hunting and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_frame_receiver_decoder (
  input  wire logic   clk,
  input  wire logic   rst,
  mfrd_in_if.sink     rx,
  mfrd_out_if.source  res
);
  import mfrd_pkg::*;

  phase_t               phase, phase_next;
  logic [7:0]           byte_count, byte_count_next;
  logic [7:0]           running_sum, running_sum_next;
  logic [ADDR_W-1:0]    address_reg, address_reg_next;
  logic [7:0]           control_reg, control_reg_next;
  logic [7:0]           length_reg, length_reg_next;
  logic [IDENT_W-1:0]   identifier_reg, identifier_reg_next;
  logic [31:0]          value_bytes, value_bytes_next;

  logic                 accept;
  logic [7:0]           b;
  logic [7:0]           d;
  logic [7:0]           count_inc;
  logic [7:0]           sum_inc;
  logic                 emit;
  status_t              emit_status;

  logic [QTY_W-1:0]     q_found;
  form_t                form;
  logic [7:0]           t0, t1, t2, t3;
  logic [VALUE_W-1:0]   val_two, val_three, val_four;
  logic [QTY_W-1:0]     q_out;
  logic [VALUE_W-1:0]   val_out;
  logic [DEC_W-1:0]     dec_out;

  assign rx.ready  = !res.valid || res.ready;
  assign accept    = rx.valid && rx.ready;
  assign b         = rx.rx_byte;
  assign d         = b - DATA_BIAS;
  assign count_inc = byte_count + 8'd1;
  assign sum_inc   = running_sum + b;

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_ADDR:   phase_next = (count_inc >= ADDR_BYTES) ? PH_START2 : PH_ADDR;
      PH_START2: phase_next = (b != START_BYTE) ? PH_HUNT : PH_CTRL;
      PH_CTRL:   phase_next = PH_LEN;
      PH_LEN:    phase_next = (b != 8'd0) ? PH_DATA : PH_CSUM;
      PH_DATA:   phase_next = (count_inc >= length_reg) ? PH_CSUM : PH_DATA;
      PH_CSUM:   phase_next = PH_HUNT;
      default:   phase_next = (b == START_BYTE) ? PH_ADDR : PH_HUNT;
    endcase
  end

  // Frame fields and result flag
  always_comb begin
    byte_count_next     = byte_count;
    running_sum_next    = running_sum;
    address_reg_next    = address_reg;
    control_reg_next    = control_reg;
    length_reg_next     = length_reg;
    identifier_reg_next = identifier_reg;
    value_bytes_next    = value_bytes;
    emit                = 1'b0;
    emit_status         = ST_OK;
    case (phase)
      PH_ADDR: begin
        address_reg_next = address_reg | (ADDR_W'(b) << {byte_count[2:0], 3'b000});
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
      end
      PH_START2: begin
        if (b != START_BYTE) begin
          emit        = 1'b1;
          emit_status = ST_BAD_START;
        end else begin
          running_sum_next = sum_inc;
        end
      end
      PH_CTRL: begin
        control_reg_next = b;
        running_sum_next = sum_inc;
      end
      PH_LEN: begin
        length_reg_next  = b;
        running_sum_next = sum_inc;
        byte_count_next  = 8'd0;
      end
      PH_DATA: begin
        if (byte_count < 8'd4) begin
          identifier_reg_next = identifier_reg |
                                (IDENT_W'(d) << {byte_count[1:0], 3'b000});
        end else if (byte_count < 8'd8) begin
          value_bytes_next = value_bytes | (32'(d) << {byte_count[1:0], 3'b000});
        end
        running_sum_next = sum_inc;
        byte_count_next  = count_inc;
      end
      PH_CSUM: begin
        emit        = 1'b1;
        emit_status = (running_sum == b) ? ST_OK : ST_CSUM_ERR;
      end
      default: begin
        if (b == START_BYTE) begin
          byte_count_next     = 8'd0;
          running_sum_next    = START_BYTE;
          address_reg_next    = '0;
          control_reg_next    = 8'd0;
          length_reg_next     = 8'd0;
          identifier_reg_next = '0;
          value_bytes_next    = '0;
        end
      end
    endcase
  end

  // Reading decode from the held frame fields
  always_comb begin
    q_found   = qty_lookup(identifier_reg);
    form      = qty_form(q_found);
    t0        = bcd_byte(value_bytes[7:0]);
    t1        = bcd_byte(value_bytes[15:8]);
    t2        = bcd_byte(value_bytes[23:16]);
    t3        = bcd_byte(value_bytes[31:24]);
    val_two   = VALUE_W'(t1) * VALUE_W'(100) + VALUE_W'(t0);
    val_three = VALUE_W'(t2) * VALUE_W'(10000) + val_two;
    val_four  = VALUE_W'(t3) * VALUE_W'(1000000) + val_three;
    q_out     = Q_UNKNOWN;
    val_out   = '0;
    dec_out   = '0;
    if (emit_status == ST_OK) begin
      q_out   = q_found;
      dec_out = qty_decimals(q_found);
      case (form)
        VF_FOUR:  val_out = val_four;
        VF_THREE: val_out = val_three;
        VF_TWO:   val_out = val_two;
        default:  val_out = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      byte_count     <= 8'd0;
      running_sum    <= 8'd0;
      address_reg    <= '0;
      control_reg    <= 8'd0;
      length_reg     <= 8'd0;
      identifier_reg <= '0;
      value_bytes    <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      running_sum    <= running_sum_next;
      address_reg    <= address_reg_next;
      control_reg    <= control_reg_next;
      length_reg     <= length_reg_next;
      identifier_reg <= identifier_reg_next;
      value_bytes    <= value_bytes_next;
    end
  end

  // Output register: load on a closing byte, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (accept && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res.frame_status    <= emit_status;
      res.meter_address   <= address_reg;
      res.control_code    <= control_reg;
      res.data_length     <= length_reg;
      res.data_identifier <= identifier_reg;
      res.quantity_code   <= q_out;
      res.measured_value  <= val_out;
      res.decimal_places  <= dec_out;
    end
  end

endmodule

`default_nettype wire

// ----- design/mfrd_checker.sv -----
// ----------------------------------------------------------------------------
// mfrd_checker
// Port-level checks on the meter frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mfrd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rx_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  frame_status,
  input wire logic [47:0] meter_address,
  input wire logic [4:0]  quantity_code,
  input wire logic [27:0] measured_value,
  input wire logic [2:0]  decimal_places
);
  import mfrd_pkg::*;

  // A stalled result holds until the transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(frame_status) &&
      $stable(meter_address) && $stable(quantity_code) && $stable(measured_value))
    else $error("result changed while stalled");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result present after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    rx_ready == (!res_valid || res_ready))
    else $error("input ready does not follow output register");

  a_error_blank: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_status != ST_OK |->
      quantity_code == Q_UNKNOWN && measured_value == '0 && decimal_places == '0)
    else $error("error result carries a reading");

  a_unknown_blank: assert property (@(posedge clk) disable iff (rst)
    res_valid && quantity_code == Q_UNKNOWN |->
      measured_value == '0 && decimal_places == '0)
    else $error("unknown quantity carries a reading");

endmodule

bind meter_frame_receiver_decoder mfrd_checker u_mfrd_checker (
  .clk            (clk),
  .rst            (rst),
  .rx_ready       (rx.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .frame_status   (res.frame_status),
  .meter_address  (res.meter_address),
  .quantity_code  (res.quantity_code),
  .measured_value (res.measured_value),
  .decimal_places (res.decimal_places)
);

`default_nettype wire
